### rtl/core/tbsc_pkg.sv
`default_nettype none
package tbsc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 8;

    localparam logic [ByteW-1:0] KeyReset = 8'hB6;
    localparam logic [ByteW-1:0] CntReset = 8'h55;

    localparam logic [CfgIdxW-1:0] RegInitialKey = 8'd0;
    localparam logic [CfgIdxW-1:0] RegInitialCounter = 8'd1;

    typedef struct packed {
        logic [ByteW-1:0] initial_key;
        logic [ByteW-1:0] initial_counter;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/core/tbsc_cfg_regs.sv
`default_nettype none
module tbsc_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tbsc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [tbsc_pkg::ByteW-1:0] i_cfg_data,
    output tbsc_pkg::t_cfg                  o_cfg
);

    tbsc_pkg::t_cfg r_cfg;
    tbsc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                tbsc_pkg::RegInitialKey:     n_cfg.initial_key = i_cfg_data;
                tbsc_pkg::RegInitialCounter: n_cfg.initial_counter = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_key <= tbsc_pkg::KeyReset;
            r_cfg.initial_counter <= tbsc_pkg::CntReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

### rtl/core/tbsc_keystream.sv
`default_nettype none
module tbsc_keystream (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic                       i_message_start,
    input  wire logic [tbsc_pkg::ByteW-1:0] i_data_byte,
    input  wire tbsc_pkg::t_cfg             i_cfg,
    output logic [tbsc_pkg::ByteW-1:0]      o_out_byte
);

    logic [tbsc_pkg::ByteW-1:0] r_key;
    logic [tbsc_pkg::ByteW-1:0] r_cnt;
    logic [tbsc_pkg::ByteW-1:0] n_key;
    logic [tbsc_pkg::ByteW-1:0] n_cnt;
    logic [tbsc_pkg::ByteW-1:0] key_use;
    logic [tbsc_pkg::ByteW-1:0] cnt_use;
    logic [tbsc_pkg::ByteW-1:0] cnt_mix;
    logic [tbsc_pkg::ByteW-1:0] quot;
    logic [tbsc_pkg::ByteW-1:0] rem9;
    logic [14:0]                prod;
    logic [tbsc_pkg::ByteW-1:0] mask;

    always_comb begin
        key_use = i_message_start ? i_cfg.initial_key : r_key;
        cnt_use = i_message_start ? i_cfg.initial_counter : r_cnt;
        cnt_mix = cnt_use;
        // update high bit first, each bit sees the ones already updated
        for (int i = 7; i >= 0; i--) begin
            if (key_use[i]) begin
                cnt_mix[i] = cnt_mix[i] ^ cnt_mix[(i + 1) % 8];
            end else begin
                cnt_mix[i] = cnt_mix[i] ^ cnt_mix[(i + 2) % 8];
            end
        end
        n_cnt = cnt_mix + 8'd1;
        n_key = key_use + 8'd1;
    end

    // n_cnt mod 9 through reciprocal 57/512, exact for 8-bit values
    always_comb begin
        prod = 15'(n_cnt) * 15'd57;
        quot = 8'(prod >> 9);
        rem9 = n_cnt - 8'(quot * 8'd9);
        if (rem9 < 8'd3) begin
            mask = 8'h55;
        end else if (rem9 <= 8'd5) begin
            mask = 8'hAA;
        end else begin
            mask = 8'hFF;
        end
        o_out_byte = i_data_byte ^ (n_cnt & mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= tbsc_pkg::KeyReset;
            r_cnt <= tbsc_pkg::CntReset;
        end else if (i_advance) begin
            r_key <= n_key;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### rtl/core/toy_byte_stream_cipher_unit.sv
// Path: input register, then the key/counter update, then the result register.
// Throughput: one byte per cycle while i_ready is high; the key/counter update is a
// single combinational pass between the input register and the result register.
// Reset: synchronous, active low; key 0xB6, counter 0x55, both initial registers
// at the same values, pipeline empty.
`default_nettype none
module toy_byte_stream_cipher_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [tbsc_pkg::ByteW-1:0]   i_data_byte,
    input  wire logic                         i_message_start,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [tbsc_pkg::ByteW-1:0]        o_out_byte,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tbsc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [tbsc_pkg::ByteW-1:0]   i_cfg_data
);

    tbsc_pkg::t_cfg cfg;

    logic                       r_in_valid;
    logic [tbsc_pkg::ByteW-1:0] r_in_data;
    logic                       r_in_start;
    logic                       r_out_valid;
    logic [tbsc_pkg::ByteW-1:0] r_out_byte;
    logic [tbsc_pkg::ByteW-1:0] ks_byte;
    logic                       advance;
    logic                       take_in;

    tbsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tbsc_keystream u_ks (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_message_start (r_in_start),
        .i_data_byte     (r_in_data),
        .i_cfg           (cfg),
        .o_out_byte      (ks_byte)
    );

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign take_in = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_out_byte = r_out_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_data <= i_data_byte;
            r_in_start <= i_message_start;
        end
        if (advance) begin
            r_out_byte <= ks_byte;
        end
    end

endmodule
`default_nettype wire
